@@ hdl/sed_pkg.sv @@
// sed_pkg: shared types, codes and character constants for the string escape decoder
// depends on: nothing

package sed_pkg;

  // decoder mode codes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  // digit run radix codes
  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // byte count saturates here
  localparam logic [15:0] COUNT_CAP = 16'hFFFF;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG1   = 8'h31;
  localparam logic [7:0] CH_DIG7   = 8'h37;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // control bytes
  localparam logic [7:0] BYTE_BS  = 8'd8;
  localparam logic [7:0] BYTE_ESC = 8'd27;
  localparam logic [7:0] BYTE_FF  = 8'd12;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_TAB = 8'd9;

  typedef struct packed {
    logic [15:0] byte_count;
    logic        bad_escape;
    logic        is_end;
    logic [7:0]  data_byte;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // digit value of c in the given radix
  function automatic digit_t digit_val(input logic [7:0] c, input logic [1:0] radix);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c >= CH_DIG0 && c <= CH_DIG9) begin
      d.ok  = 1'b1;
      d.val = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      d.ok  = 1'b1;
      d.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    if (radix == RADIX_OCT && d.val >= 4'd8) d.ok = 1'b0;
    else if (radix == RADIX_DEC && d.val >= 4'd10) d.ok = 1'b0;
    return d;
  endfunction

endpackage

@@ hdl/string_escape_decoder_top.sv @@
// string_escape_decoder_top: backslash escape decoder, one character per beat
// depends on: sed_pkg

// channel | dir | ports                                   | payload
// in_     | in  | in_tvalid, in_tready, in_tdata[7:0]      | char_in
// out_    | out | out_tvalid, out_tready, out_tdata[23:0], | data_byte, byte_count,
//         |     | out_tlast, out_tuser                     | is_end, bad_escape
//
// a character is decoded in the cycle it is taken and its 0..2 results are written
// into a four-entry result queue; results leave one per cycle while out_tready is high,
// from the cycle after entry; one character per cycle sustained while the output keeps
// up; in_tready drops when the queue has fewer than two free slots
// rst_n (synchronous) empties the queue and returns the decoder to normal mode

module string_escape_decoder_top
  import sed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [23:8] byte_count
  output logic        out_tlast,  // is_end
  output logic        out_tuser   // bad_escape
);

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  radix_r, radix_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [9:0]  acc_r, acc_nxt;
  logic        have_r, have_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  res_t        fifo_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  fcnt_r;

  logic        in_fire, out_fire;
  logic [7:0]  c;
  digit_t      dv;
  logic [9:0]  acc_mul;
  logic        ea, eb, b_end, b_bad, run_normal;
  logic [7:0]  av, b_byte;
  logic [15:0] cnt_a, end_count;
  res_t        res_a, res_b, wr0, wr1;
  logic [1:0]  n_push;

  assign c         = in_tdata;
  assign in_tready = (fcnt_r <= 3'd2);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (fcnt_r != 3'd0);
  assign out_fire  = out_tvalid && out_tready;

  assign dv = digit_val(c, radix_r);

  always_comb begin
    case (radix_r)
      RADIX_DEC: acc_mul = (acc_r << 3) + (acc_r << 1) + {6'd0, dv.val};
      RADIX_HEX: acc_mul = (acc_r << 4) + {6'd0, dv.val};
      default:   acc_mul = (acc_r << 3) + {6'd0, dv.val};
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    radix_nxt  = radix_r;
    left_nxt   = left_r;
    acc_nxt    = acc_r;
    have_nxt   = have_r;
    ea         = 1'b0;
    av         = 8'd0;
    eb         = 1'b0;
    b_end      = 1'b0;
    b_bad      = 1'b0;
    b_byte     = 8'd0;
    run_normal = 1'b0;

    case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        case (c)
          CH_NUL: begin
            eb = 1'b1; b_end = 1'b1; b_bad = 1'b1;
          end
          CH_DIG0, CH_O, CH_D: begin
            mode_nxt  = MODE_DIGITS;
            radix_nxt = (c == CH_D) ? RADIX_DEC : RADIX_OCT;
            left_nxt  = 3'd3;
            acc_nxt   = 10'd0;
            have_nxt  = (c == CH_DIG0);
          end
          CH_X: begin
            mode_nxt  = MODE_DIGITS;
            radix_nxt = RADIX_HEX;
            left_nxt  = 3'd2;
            acc_nxt   = 10'd0;
            have_nxt  = 1'b0;
          end
          CH_B: begin eb = 1'b1; b_byte = BYTE_BS;  end
          CH_E: begin eb = 1'b1; b_byte = BYTE_ESC; end
          CH_LF: begin eb = 1'b1; b_byte = BYTE_FF; end
          CH_N: begin eb = 1'b1; b_byte = BYTE_LF;  end
          CH_R: begin eb = 1'b1; b_byte = BYTE_CR;  end
          CH_T: begin eb = 1'b1; b_byte = BYTE_TAB; end
          default: begin
            if (c >= CH_DIG1 && c <= CH_DIG7) begin
              mode_nxt  = MODE_DIGITS;
              radix_nxt = RADIX_OCT;
              left_nxt  = 3'd2;
              acc_nxt   = {7'd0, c[2:0]};
              have_nxt  = 1'b1;
            end else begin
              eb = 1'b1; b_byte = c;
            end
          end
        endcase
      end
      MODE_DIGITS: begin
        if (dv.ok && left_r != 3'd0) begin
          left_nxt = left_r - 3'd1;
          acc_nxt  = acc_mul;
          have_nxt = 1'b1;
          if (left_r == 3'd1) begin
            mode_nxt = MODE_NORMAL;
            ea       = 1'b1;
            av       = acc_mul[7:0];
            acc_nxt  = 10'd0;
            have_nxt = 1'b0;
          end
        end else begin
          // run ended on a non-digit: flush, then treat the character as plain
          mode_nxt   = MODE_NORMAL;
          ea         = have_r;
          av         = acc_r[7:0];
          acc_nxt    = 10'd0;
          have_nxt   = 1'b0;
          left_nxt   = 3'd0;
          run_normal = 1'b1;
        end
      end
      default: begin
        mode_nxt   = MODE_NORMAL;
        run_normal = 1'b1;
      end
    endcase

    if (run_normal) begin
      if (c == CH_NUL) begin
        eb = 1'b1; b_end = 1'b1;
      end else if (c == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        eb = 1'b1; b_byte = c;
      end
    end
  end

  // byte count through both possible results
  always_comb begin
    cnt_a     = (ea && cnt_r != COUNT_CAP) ? cnt_r + 16'd1 : cnt_r;
    end_count = b_bad ? 16'd0 : cnt_a;
    cnt_nxt   = cnt_a;
    if (eb && !b_end && cnt_a != COUNT_CAP) cnt_nxt = cnt_a + 16'd1;
  end

  always_comb begin
    res_a.data_byte  = av;
    res_a.is_end     = 1'b0;
    res_a.bad_escape = 1'b0;
    res_a.byte_count = 16'd0;
    res_b.data_byte  = b_end ? 8'd0 : b_byte;
    res_b.is_end     = b_end;
    res_b.bad_escape = b_bad;
    res_b.byte_count = b_end ? end_count : 16'd0;
    wr0    = ea ? res_a : res_b;
    wr1    = res_b;
    n_push = {1'b0, ea} + {1'b0, eb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      radix_r <= RADIX_OCT;
      left_r  <= 3'd0;
      acc_r   <= 10'd0;
      have_r  <= 1'b0;
      cnt_r   <= 16'd0;
    end else if (in_fire) begin
      if (b_end) begin
        mode_r  <= MODE_NORMAL;
        radix_r <= RADIX_OCT;
        left_r  <= 3'd0;
        acc_r   <= 10'd0;
        have_r  <= 1'b0;
        cnt_r   <= 16'd0;
      end else begin
        mode_r  <= mode_nxt;
        radix_r <= radix_nxt;
        left_r  <= left_nxt;
        acc_r   <= acc_nxt;
        have_r  <= have_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (n_push != 2'd0) fifo_r[wp_r] <= wr0;
      if (n_push == 2'd2) fifo_r[wp_r + 2'd1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 2'd0;
      rp_r   <= 2'd0;
      fcnt_r <= 3'd0;
    end else begin
      if (in_fire) wp_r <= wp_r + n_push;
      if (out_fire) rp_r <= rp_r + 2'd1;
      fcnt_r <= fcnt_r + (in_fire ? {1'b0, n_push} : 3'd0) - {2'd0, out_fire};
    end
  end

  assign out_tdata = {fifo_r[rp_r].byte_count, fifo_r[rp_r].data_byte};
  assign out_tlast = fifo_r[rp_r].is_end;
  assign out_tuser = fifo_r[rp_r].bad_escape;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 3'd4)
    else $error("result queue overflow");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tdata == CH_NUL |=> mode_r == MODE_NORMAL && cnt_r == 16'd0
      && left_r == 3'd0 && !have_r)
    else $error("decoder state not cleared after end of string");

  a_bad_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 24'd0)
    else $error("bad escape flag on a non-end or nonzero result");

  a_data_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[23:8] == 16'd0 && !out_tuser)
    else $error("count or flag on a data result");

endmodule

@@ tb/string_escape_decoder_top_test.sv @@
// testbench for string_escape_decoder_top: drives strings one character per beat and
// checks every decoded byte and end-of-string beat against a behavioral decoder
// depends on: sed_pkg, string_escape_decoder_top

`timescale 1ns / 100ps

module string_escape_decoder_top_test;
  import sed_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  string_escape_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decoder state mirrored by the testbench
  logic [1:0]  dec_mode  = MODE_NORMAL;
  logic [1:0]  dec_radix = RADIX_OCT;
  logic [2:0]  dec_left  = 3'd0;
  logic [9:0]  dec_accum = 10'd0;
  logic        dec_have  = 1'b0;
  logic [15:0] dec_count = 16'd0;

  res_t expected_bytes[$];
  res_t want_res;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int chars_sent    = 0;
  int bytes_checked = 0;
  int ends_checked  = 0;

  logic [7:0] simple_codes[6] = '{CH_B, CH_E, CH_LF, CH_N, CH_R, CH_T};

  // ---------------------------------------------------------------- decoder model

  function automatic int digit_of(input logic [7:0] c, input logic [1:0] radix);
    int v;
    v = -1;
    if (c >= CH_DIG0 && c <= CH_DIG9) v = c - CH_DIG0;
    else if (c >= CH_LA && c <= CH_LF) v = c - CH_LA + 10;
    else if (c >= CH_UA && c <= CH_UF) v = c - CH_UA + 10;
    if (radix == RADIX_OCT && v >= 8) v = -1;
    else if (radix == RADIX_DEC && v >= 10) v = -1;
    return v;
  endfunction

  task automatic clear_decoder();
    dec_mode  = MODE_NORMAL;
    dec_radix = RADIX_OCT;
    dec_left  = 3'd0;
    dec_accum = 10'd0;
    dec_have  = 1'b0;
    dec_count = 16'd0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.data_byte = b;
    expected_bytes.push_back(r);
    if (dec_count != COUNT_CAP) dec_count++;
  endtask

  task automatic push_end(input logic bad);
    res_t r;
    r = '0;
    r.is_end     = 1'b1;
    r.bad_escape = bad;
    r.byte_count = bad ? 16'd0 : dec_count;
    expected_bytes.push_back(r);
    clear_decoder();
  endtask

  task automatic start_run(input logic [1:0] radix, input logic [2:0] left,
                           input logic [9:0] first, input logic have);
    dec_mode  = MODE_DIGITS;
    dec_radix = radix;
    dec_left  = left;
    dec_accum = first;
    dec_have  = have;
  endtask

  task automatic decode_plain(input logic [7:0] c);
    if (c == CH_NUL) push_end(1'b0);
    else if (c == CH_BSLASH) dec_mode = MODE_ESC;
    else push_byte(c);
  endtask

  task automatic decode_char(input logic [7:0] c);
    int v;
    int mul;
    if (dec_mode == MODE_ESC) begin
      dec_mode = MODE_NORMAL;
      case (c)
        CH_NUL:  push_end(1'b1);
        CH_DIG0: start_run(RADIX_OCT, 3'd3, 10'd0, 1'b1);
        CH_O:    start_run(RADIX_OCT, 3'd3, 10'd0, 1'b0);
        CH_D:    start_run(RADIX_DEC, 3'd3, 10'd0, 1'b0);
        CH_X:    start_run(RADIX_HEX, 3'd2, 10'd0, 1'b0);
        CH_B:    push_byte(BYTE_BS);
        CH_E:    push_byte(BYTE_ESC);
        CH_LF:   push_byte(BYTE_FF);
        CH_N:    push_byte(BYTE_LF);
        CH_R:    push_byte(BYTE_CR);
        CH_T:    push_byte(BYTE_TAB);
        default: begin
          if (c >= CH_DIG1 && c <= CH_DIG7) start_run(RADIX_OCT, 3'd2, 10'(c - CH_DIG0), 1'b1);
          else push_byte(c);
        end
      endcase
    end else if (dec_mode == MODE_DIGITS) begin
      v   = digit_of(c, dec_radix);
      mul = (dec_radix == RADIX_DEC) ? 10 : (dec_radix == RADIX_HEX) ? 16 : 8;
      if (v >= 0 && dec_left != 3'd0) begin
        dec_accum = 10'(int'(dec_accum) * mul + v);
        dec_left  = dec_left - 3'd1;
        dec_have  = 1'b1;
        if (dec_left == 3'd0) begin
          dec_mode = MODE_NORMAL;
          push_byte(dec_accum[7:0]);
          dec_accum = 10'd0;
          dec_have  = 1'b0;
        end
      end else begin
        // run cut short: flush the pending byte, then the character counts as plain
        dec_mode = MODE_NORMAL;
        if (dec_have) push_byte(dec_accum[7:0]);
        dec_accum = 10'd0;
        dec_have  = 1'b0;
        dec_left  = 3'd0;
        decode_plain(c);
      end
    end else begin
      dec_mode = MODE_NORMAL;
      decode_plain(c);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    decode_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_digit(input logic [1:0] radix);
    int v;
    if (radix == RADIX_OCT) return 8'(CH_DIG0 + $urandom_range(7));
    if (radix == RADIX_DEC) return 8'(CH_DIG0 + $urandom_range(9));
    v = $urandom_range(21);
    if (v < 10) return 8'(CH_DIG0 + v);
    if (v < 16) return 8'(CH_LA + v - 10);
    return 8'(CH_UA + v - 16);
  endfunction

  task automatic send_digits(input logic [1:0] radix, input int count);
    for (int i = 0; i < count; i++) send_char(rand_digit(radix));
  endtask

  // mostly well-formed strings with random content, plus some raw noise
  task automatic send_random_string();
    int segs;
    int kind;
    logic [7:0] c;
    segs = $urandom_range(12, 1);
    for (int s = 0; s < segs; s++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        do c = 8'($urandom_range(255, 1)); while (c == CH_BSLASH);
        send_char(c);
      end else if (kind < 55) begin
        send_char(CH_BSLASH);
        send_char(simple_codes[$urandom_range(5)]);
      end else if (kind < 85) begin
        send_char(CH_BSLASH);
        case ($urandom_range(4))
          0: begin
            send_char(CH_DIG0);
            send_digits(RADIX_OCT, $urandom_range(4));
          end
          1: begin
            send_char(8'(CH_DIG1 + $urandom_range(6)));
            send_digits(RADIX_OCT, $urandom_range(3));
          end
          2: begin
            send_char(CH_O);
            send_digits(RADIX_OCT, $urandom_range(4));
          end
          3: begin
            send_char(CH_D);
            send_digits(RADIX_DEC, $urandom_range(4));
          end
          default: begin
            send_char(CH_X);
            send_digits(RADIX_HEX, $urandom_range(3));
          end
        endcase
      end else if (kind < 95) begin
        send_char(CH_BSLASH);
        send_char(8'($urandom_range(255, 1)));
      end else begin
        // raw byte, may end the string early
        send_char(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(19) == 0) send_char(CH_BSLASH);
    send_char(CH_NUL);
  endtask

  // stop offering beats, then wait for every expected result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_extremes();
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CH_NUL);
  endtask

  task automatic test_control_escapes();
    // escaped 9 passes through as itself
    send_text("\\n\\e\\9");
    send_char(CH_NUL);
  endtask

  task automatic test_numeric_escapes();
    // octal overflow wraps, hex with no digits emits nothing, decimal cut short,
    // and the string ends inside an octal run
    send_text("\\777\\xg\\d1z\\0");
    send_char(CH_NUL);
  endtask

  task automatic test_bad_end();
    send_char(CH_BSLASH);
    send_char(CH_NUL);
  endtask

  task automatic test_random_strings(input int count);
    int stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) send_random_string();
  endtask

  // ---------------------------------------------------------------- result check

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none actual data %0h last %0b user %0b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        want_res = expected_bytes.pop_front();
        check_field("data_byte", want_res.data_byte, out_tdata[7:0]);
        check_field("byte_count", want_res.byte_count, out_tdata[23:8]);
        check_field("is_end", want_res.is_end, out_tlast);
        check_field("bad_escape", want_res.bad_escape, out_tuser);
        if (want_res.is_end) ends_checked++;
        else bytes_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 82;
    test_extremes();
    test_control_escapes();
    test_numeric_escapes();
    test_bad_end();
    test_random_strings(350);
    wait_drained();

    send_idle_pct = 82;
    recv_idle_pct = 20;
    test_random_strings(350);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_strings(350);
    wait_drained();

    $display("sent %0d characters; checked %0d decoded bytes and %0d string ends",
             chars_sent, bytes_checked, ends_checked);
    $display("covered control, octal, decimal and hex escapes, cut runs and bad ends");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_bytes.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sed_pkg.sv
hdl/string_escape_decoder_top.sv
tb/string_escape_decoder_top_test.sv
